// File: design/cpl_pkg.sv
// shared types, widths and codes for the closest point on line block
// no dependencies
`timescale 1ns / 1ps
package cpl_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W = 32;
   localparam int OP_W = 33;     // sign-extended operand or difference
   localparam int PROD_W = 66;   // 33 x 33 product
   localparam int DEN_W = 66;    // unsigned sum of two squares
   localparam int TN_W = 67;     // signed sum of two products
   localparam int PH_W = 68;     // upper partial product
   localparam int NUM_W = 104;   // dividend width, holds shifts up to 24 fraction bits
   localparam int Q_W = 34;      // quotient bits developed by the cell row
   localparam int RES_W = Q_W + 2;

   localparam logic [1:0] MODE_GENERAL = 2'd0;
   localparam logic [1:0] MODE_PARAM = 2'd1;
   localparam logic [1:0] MODE_SEGMENT = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DEGEN = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_WORD0 = 3'd1;
   localparam logic [2:0] REG_WORD1 = 3'd2;
   localparam logic [2:0] REG_WORD2 = 3'd3;
   localparam logic [2:0] REG_WORD3 = 3'd4;

   typedef enum logic [1:0] {
      KIND_OK,
      KIND_DEGEN,
      KIND_LO,
      KIND_HI
   } cpl_kind_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] word0;
      logic signed [DATA_W-1:0] word1;
      logic signed [DATA_W-1:0] word2;
      logic signed [DATA_W-1:0] word3;
   } cpl_cfg_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [Q_W-1:0]   num;
      logic [Q_W-1:0]   quo;
      logic             neg;
      logic             ovf;
   } cpl_lane_type;

   typedef struct packed {
      logic              valid;
      cpl_kind_type      kind;
      logic [DEN_W-1:0]  den;
      cpl_lane_type [2:0] lane;
   } cpl_div_type;

   // floor quotient from magnitude quotient, then clamp to 32 bits; msb is the sat flag
   function automatic logic [DATA_W:0] sat_lane(cpl_lane_type ln);
      logic signed [RES_W-1:0] v;
      logic                    sat;
      logic [DATA_W-1:0]       r;
      v = $signed({2'b00, ln.quo});
      if (ln.neg) begin
         v = -v - ((ln.rem != '0) ? RES_W'(1) : RES_W'(0));
      end
      sat = 1'b0;
      r = v[DATA_W-1:0];
      if (ln.ovf) begin
         sat = 1'b1;
         r = ln.neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v > $signed({{(RES_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}})) begin
         sat = 1'b1;
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < $signed({{(RES_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}})) begin
         sat = 1'b1;
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end
      return {sat, r};
   endfunction

endpackage

// File: design/cpl_front.sv
// products, numerators and divider setup for the closest point block
// depends on cpl_pkg
`timescale 1ns / 1ps
module cpl_front import cpl_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [DATA_W-1:0] point_x,
   input  logic signed [DATA_W-1:0] point_y,
   input  cpl_cfg_type              cfg,
   output cpl_div_type              div_out
);

   logic                     s1_valid_ff;
   logic signed [DATA_W-1:0] s1_px_ff, s1_py_ff;

   logic                     s2_valid_ff;
   logic signed [OP_W-1:0]   s2_u_ff, s2_v_ff, s2_px_ff, s2_py_ff;
   logic signed [PROD_W-1:0] s2_pa_ff, s2_pb_ff, s2_pc_ff, s2_pd_ff, s2_pe_ff;

   logic                     s3_valid_ff;
   logic [DEN_W-1:0]         s3_den_ff;
   logic signed [TN_W-1:0]   s3_tn_ff;
   logic signed [PROD_W-1:0] s3_pd_ff, s3_pe_ff;
   logic signed [TN_W-1:0]   s3_a_ff [4];
   logic signed [OP_W-1:0]   s3_b_ff [4];

   logic                     s4_valid_ff;
   logic [DEN_W-1:0]         s4_den_ff;
   logic signed [TN_W-1:0]   s4_tn_ff;
   logic signed [PROD_W-1:0] s4_pd_ff, s4_pe_ff;
   logic signed [PROD_W-1:0] s4_lo_ff [4];
   logic signed [PH_W-1:0]   s4_hi_ff [4];

   logic                     s5_valid_ff;
   logic [DEN_W-1:0]         s5_den_ff;
   logic signed [TN_W-1:0]   s5_tn_ff;
   logic signed [PROD_W-1:0] s5_pd_ff, s5_pe_ff;
   logic signed [NUM_W-1:0]  s5_p_ff [4];

   logic                     s6_valid_ff;
   logic [DEN_W-1:0]         s6_den_ff;
   cpl_kind_type             s6_kind_ff;
   logic signed [NUM_W-1:0]  s6_n_ff [3];

   cpl_div_type              div_ff;

   // stage 2 operands
   logic signed [OP_W-1:0]   w0, w1, w2, w3, u_in, v_in, dx, dy, px, py;
   logic                     general;
   // stage 3
   logic signed [TN_W-1:0]   den_sum, tn_in;
   // stage 6
   logic signed [NUM_W-1:0]  n_in [3];
   cpl_kind_type             kind_in;
   // stage 7
   cpl_div_type              div_in;

   always_comb begin
      w0 = OP_W'(cfg.word0);
      w1 = OP_W'(cfg.word1);
      w2 = OP_W'(cfg.word2);
      w3 = OP_W'(cfg.word3);
      px = OP_W'(s1_px_ff);
      py = OP_W'(s1_py_ff);
      general = (cfg.mode == MODE_GENERAL);
      case (cfg.mode)
         MODE_GENERAL: begin
            u_in = w0;
            v_in = w1;
         end
         MODE_PARAM: begin
            u_in = w2;
            v_in = w3;
         end
         default: begin
            u_in = w2 - w0;
            v_in = w3 - w1;
         end
      endcase
      dx = px - w0;
      dy = py - w1;
   end

   always_comb begin
      den_sum = TN_W'(s2_pa_ff) + TN_W'(s2_pb_ff);
      tn_in = TN_W'(s2_pc_ff) + TN_W'(s2_pd_ff);
   end

   always_comb begin
      if (cfg.mode == MODE_GENERAL) begin
         n_in[0] = s5_p_ff[0] - s5_p_ff[1] - (NUM_W'(s5_pd_ff) <<< FRAC_BITS);
         n_in[1] = s5_p_ff[2] - s5_p_ff[3] - (NUM_W'(s5_pe_ff) <<< FRAC_BITS);
         n_in[2] = '0;
      end else begin
         n_in[0] = s5_p_ff[0] + s5_p_ff[1];
         n_in[1] = s5_p_ff[2] + s5_p_ff[3];
         n_in[2] = NUM_W'(s5_tn_ff) <<< FRAC_BITS;
      end
      if (cfg.mode == 2'd3 || s5_den_ff == '0) begin
         kind_in = KIND_DEGEN;
      end else if (cfg.mode == MODE_SEGMENT && s5_tn_ff < 0) begin
         kind_in = KIND_LO;
      end else if (cfg.mode == MODE_SEGMENT && s5_tn_ff > $signed({1'b0, s5_den_ff})) begin
         kind_in = KIND_HI;
      end else begin
         kind_in = KIND_OK;
      end
   end

   // divider setup: magnitude, overflow of the high part, first remainder
   always_comb begin
      logic [NUM_W-1:0] mag;
      logic [NUM_W-Q_W-1:0] top;
      div_in.valid = s6_valid_ff;
      div_in.kind = s6_kind_ff;
      div_in.den = s6_den_ff;
      for (int k = 0; k < 3; k++) begin
         div_in.lane[k].neg = s6_n_ff[k][NUM_W-1];
         mag = s6_n_ff[k][NUM_W-1] ? NUM_W'(-s6_n_ff[k]) : NUM_W'(s6_n_ff[k]);
         top = mag[NUM_W-1:Q_W];
         div_in.lane[k].ovf = (top >= (NUM_W-Q_W)'(s6_den_ff));
         div_in.lane[k].rem = top[DEN_W-1:0];
         div_in.lane[k].num = mag[Q_W-1:0];
         div_in.lane[k].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         div_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         div_ff.valid <= div_in.valid;
      end
      s1_px_ff <= point_x;
      s1_py_ff <= point_y;

      s2_u_ff <= u_in;
      s2_v_ff <= v_in;
      s2_px_ff <= px;
      s2_py_ff <= py;
      s2_pa_ff <= u_in * u_in;
      s2_pb_ff <= v_in * v_in;
      s2_pc_ff <= general ? u_in * v_in : u_in * dx;
      s2_pd_ff <= general ? u_in * w2 : v_in * dy;
      s2_pe_ff <= v_in * w2;

      s3_den_ff <= den_sum[DEN_W-1:0];
      s3_tn_ff <= tn_in;
      s3_pd_ff <= s2_pd_ff;
      s3_pe_ff <= s2_pe_ff;
      if (cfg.mode == MODE_GENERAL) begin
         s3_a_ff[0] <= TN_W'(s2_pb_ff);
         s3_b_ff[0] <= s2_px_ff;
         s3_a_ff[1] <= TN_W'(s2_pc_ff);
         s3_b_ff[1] <= s2_py_ff;
         s3_a_ff[2] <= TN_W'(s2_pa_ff);
         s3_b_ff[2] <= s2_py_ff;
         s3_a_ff[3] <= TN_W'(s2_pc_ff);
         s3_b_ff[3] <= s2_px_ff;
      end else begin
         s3_a_ff[0] <= den_sum;
         s3_b_ff[0] <= w0;
         s3_a_ff[1] <= tn_in;
         s3_b_ff[1] <= s2_u_ff;
         s3_a_ff[2] <= den_sum;
         s3_b_ff[2] <= w1;
         s3_a_ff[3] <= tn_in;
         s3_b_ff[3] <= s2_v_ff;
      end

      // split each wide product into two narrow ones
      s4_den_ff <= s3_den_ff;
      s4_tn_ff <= s3_tn_ff;
      s4_pd_ff <= s3_pd_ff;
      s4_pe_ff <= s3_pe_ff;
      for (int k = 0; k < 4; k++) begin
         s4_lo_ff[k] <= $signed({1'b0, s3_a_ff[k][31:0]}) * s3_b_ff[k];
         s4_hi_ff[k] <= $signed(s3_a_ff[k][TN_W-1:32]) * s3_b_ff[k];
      end

      s5_den_ff <= s4_den_ff;
      s5_tn_ff <= s4_tn_ff;
      s5_pd_ff <= s4_pd_ff;
      s5_pe_ff <= s4_pe_ff;
      for (int k = 0; k < 4; k++) begin
         s5_p_ff[k] <= (NUM_W'(s4_hi_ff[k]) <<< 32) + NUM_W'(s4_lo_ff[k]);
      end

      s6_den_ff <= s5_den_ff;
      s6_kind_ff <= kind_in;
      for (int k = 0; k < 3; k++) begin
         s6_n_ff[k] <= n_in[k];
      end

      div_ff.kind <= div_in.kind;
      div_ff.den <= div_in.den;
      div_ff.lane <= div_in.lane;
   end

   assign div_out = div_ff;

endmodule

// File: design/cpl_div_cell.sv
// one restoring divide step for the x, y and t quotients
// depends on cpl_pkg
`timescale 1ns / 1ps
module cpl_div_cell import cpl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cpl_div_type div_in,
   output cpl_div_type div_out
);

   cpl_div_type div_ff;
   cpl_div_type div_nx;

   always_comb begin
      logic [DEN_W:0] trial;
      div_nx = div_in;
      for (int k = 0; k < 3; k++) begin
         trial = {div_in.lane[k].rem, div_in.lane[k].num[Q_W-1]};
         div_nx.lane[k].num = {div_in.lane[k].num[Q_W-2:0], 1'b0};
         if (trial >= {1'b0, div_in.den}) begin
            div_nx.lane[k].rem = DEN_W'(trial - {1'b0, div_in.den});
            div_nx.lane[k].quo = {div_in.lane[k].quo[Q_W-2:0], 1'b1};
         end else begin
            div_nx.lane[k].rem = trial[DEN_W-1:0];
            div_nx.lane[k].quo = {div_in.lane[k].quo[Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else begin
         div_ff.valid <= div_nx.valid;
      end
      div_ff.kind <= div_nx.kind;
      div_ff.den <= div_nx.den;
      div_ff.lane <= div_nx.lane;
   end

   assign div_out = div_ff;

endmodule

// File: design/closest_point_on_line_2d_top.sv
// top level: config registers, front end, row of divide cells, result stage
// depends on cpl_pkg, cpl_front and cpl_div_cell
`timescale 1ns / 1ps
// an accepted item passes through 7 front stages, 34 divide cells and 1 result register,
// and rsp_valid rises when it reaches the result register
// throughput: one item per cycle, busy stays low; the 34-cell divide row sets the latency
// results cannot be stalled, each is shown for one cycle on rsp_valid
// synchronous reset clears the line registers to zero and empties the pipeline
module closest_point_on_line_2d_top import cpl_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_point_x,
   input  logic signed [DATA_W-1:0] req_point_y,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_near_x,
   output logic signed [DATA_W-1:0] rsp_near_y,
   output logic signed [DATA_W-1:0] rsp_line_param,
   output logic [1:0]               rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   cpl_cfg_type cfg_ff;
   cpl_div_type chain [Q_W+1];

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] near_x_ff, near_y_ff, param_ff;
   logic [1:0]               status_ff;

   logic [DATA_W:0]          rx, ry, rt;
   logic [DATA_W-1:0]        near_x_in, near_y_in, param_in;
   logic [1:0]               status_in;
   cpl_div_type              fin;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:  cfg_ff.mode <= csr_data[1:0];
            REG_WORD0: cfg_ff.word0 <= csr_data;
            REG_WORD1: cfg_ff.word1 <= csr_data;
            REG_WORD2: cfg_ff.word2 <= csr_data;
            REG_WORD3: cfg_ff.word3 <= csr_data;
            default: ;
         endcase
      end
   end

   cpl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .cfg      (cfg_ff),
      .div_out  (chain[0])
   );

   for (genvar i = 0; i < Q_W; i++) begin : g_cell
      cpl_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .div_in  (chain[i]),
         .div_out (chain[i+1])
      );
   end

   always_comb begin
      fin = chain[Q_W];
      rx = sat_lane(fin.lane[0]);
      ry = sat_lane(fin.lane[1]);
      rt = sat_lane(fin.lane[2]);
      case (fin.kind)
         KIND_DEGEN: begin
            near_x_in = '0;
            near_y_in = '0;
            param_in = '0;
            status_in = ST_DEGEN;
         end
         KIND_LO: begin
            near_x_in = cfg_ff.word0;
            near_y_in = cfg_ff.word1;
            param_in = '0;
            status_in = ST_OK;
         end
         KIND_HI: begin
            near_x_in = cfg_ff.word2;
            near_y_in = cfg_ff.word3;
            param_in = DATA_W'(1) << FRAC_BITS;
            status_in = ST_OK;
         end
         default: begin
            near_x_in = rx[DATA_W-1:0];
            near_y_in = ry[DATA_W-1:0];
            param_in = rt[DATA_W-1:0];
            status_in = (rx[DATA_W] | ry[DATA_W] | rt[DATA_W]) ? ST_SAT : ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.valid;
      end
      near_x_ff <= near_x_in;
      near_y_ff <= near_y_in;
      param_ff <= param_in;
      status_ff <= status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_near_x = near_x_ff;
   assign rsp_near_y = near_y_ff;
   assign rsp_line_param = param_ff;
   assign rsp_status = status_ff;

endmodule
